// File: design/kpct_pkg.sv
// Shared types and codes for the keyed pending coalesce table.
package kpct_pkg;

    // Table geometry and key/value widths.
    localparam int TABLE_DEPTH = 32;
    localparam int KEY_BITS    = 64;
    localparam int VALUE_BITS  = 32;
    localparam int IGNORE_KEYS = 4;

    localparam logic [1:0] OP_MERGE = 2'd0;
    localparam logic [1:0] OP_FLUSH = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [1:0] KIND_ACK   = 2'd0;
    localparam logic [1:0] KIND_ENTRY = 2'd1;
    localparam logic [1:0] KIND_VERD  = 2'd2;
    localparam logic [1:0] KIND_EMPTY = 2'd3;

    localparam logic [1:0] MS_UPDATED  = 2'd0;
    localparam logic [1:0] MS_INSERTED = 2'd1;
    localparam logic [1:0] MS_DROPPED  = 2'd2;

    localparam logic [1:0] VD_NONE    = 2'd0;
    localparam logic [1:0] VD_MISSING = 2'd1;
    localparam logic [1:0] VD_DIFFER  = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_IGN_A    = 3'd0;
    localparam logic [2:0] REG_IGN_B    = 3'd1;
    localparam logic [2:0] REG_IGN_C    = 3'd2;
    localparam logic [2:0] REG_IGN_D    = 3'd3;
    localparam logic [2:0] REG_IGN_USED = 3'd4;

    localparam int MAX_FLUSH = 32;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the input item
        logic scan_start; // reset the scan index
        logic scan_step;  // read slot at scan index, advance
        logic write_val;  // overwrite value at match slot
        logic append;     // write new entry at fill
        logic flush_rd;   // read oldest-side slot for flush
        logic move_step;  // move one entry toward the front
        logic flush_done; // apply fill decrease
        logic out_load;   // load result register
        logic [1:0] out_kind;
        logic out_last;
    } kpct_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] op;
        logic scan_end;    // scan index reached fill
        logic hit;         // a match has been found
        logic full;
        logic listed;
        logic flush_empty; // flush count is zero
        logic flush_last;  // current emitted entry is the last
        logic move_end;    // no more entries to move
        logic out_busy;    // result register still holds a transfer
    } kpct_stat_t;

endpackage

// File: design/keyed_pending_coalesce_table.sv
// Top level of the keyed pending coalesce table.
// Holds up to TABLE_DEPTH key/value entries in insertion order. A merge
// scans the table one slot per cycle and stops at the first matching key,
// then updates, appends or drops and returns one ack; an item passes
// through decode, the scan, a settle state and the result state before
// the block is ready again. A query checks the ignore list, scans the
// same way and returns one verdict. A flush emits the oldest
// n = min(fill, limit, 32) entries, then moves the remaining fill-n
// entries to the front one per cycle. The entry memories give one read
// per cycle. A stalled result keeps the item waiting until the result
// register is free. One item is in work at a time; the result register
// lets the last transfer wait while the next item is taken. fill_after
// always reports the fill after the item, so every flushed entry carries
// the post-flush fill.
module keyed_pending_coalesce_table import kpct_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // attr_key[63:0], attr_value[95:64], flush_limit[101:96], zero fill
    input  logic [103:0] s_tdata,
    // op[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // entry_key[63:0], entry_value[95:64], verdict[97:96], slot_index[102:98],
    // merge_status[104:103], fill_after[110:105], zero fill
    output logic [111:0] m_tdata,
    // kind[1:0]
    output logic [1:0]   m_tuser,
    output logic         m_tlast
);
    logic [KEY_BITS-1:0] ign_key_reg [IGNORE_KEYS];
    logic [2:0]          ign_used_reg, used_c;
    kpct_cmd_t  cmd;
    kpct_stat_t stat;

    // Hold ignore-list registers; clamp the used count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < IGNORE_KEYS; i++) ign_key_reg[i] <= '0;
            ign_used_reg <= '0;
        end else if (cfg_we) begin
            for (int i = 0; i < IGNORE_KEYS; i++) begin
                if (32'(cfg_index) == i) ign_key_reg[i] <= cfg_wdata[KEY_BITS-1:0];
            end
            if (cfg_index == REG_IGN_USED) ign_used_reg <= cfg_wdata[2:0];
        end
    end
    assign used_c = (32'(ign_used_reg) > IGNORE_KEYS) ? 3'(IGNORE_KEYS) : ign_used_reg;

    logic [1:0]            o_verd, o_stat;
    logic [KEY_BITS-1:0]   o_key;
    logic [VALUE_BITS-1:0] o_val;
    logic [4:0]            o_slot;
    logic [5:0]            o_fill;

    kpct_ctrl u_ctrl (
        .aclk, .aresetn, .in_valid(s_tvalid), .in_ready(s_tready),
        .stat, .cmd
    );

    kpct_datapath u_dp (
        .aclk, .aresetn, .cmd, .stat,
        .in_op(s_tuser), .in_key(s_tdata[0 +: KEY_BITS]),
        .in_value(s_tdata[KEY_BITS +: VALUE_BITS]),
        .in_limit(s_tdata[KEY_BITS + VALUE_BITS +: 6]),
        .ign_key(ign_key_reg), .ign_used(used_c),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_kind(m_tuser), .out_key(o_key), .out_value(o_val),
        .out_verdict(o_verd), .out_slot(o_slot), .out_status(o_stat),
        .out_fill(o_fill), .out_last(m_tlast)
    );

    // Pack the result fields, lowest field first.
    assign m_tdata = {1'b0, o_fill, o_stat, o_slot, o_verd, o_val, o_key};
endmodule

// File: design/kpct_datapath.sv
// Datapath: entry memories, scan and move counters, result register.
module kpct_datapath import kpct_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  kpct_cmd_t             cmd,
    output kpct_stat_t            stat,
    input  logic [1:0]            in_op,
    input  logic [KEY_BITS-1:0]   in_key,
    input  logic [VALUE_BITS-1:0] in_value,
    input  logic [5:0]            in_limit,
    input  logic [KEY_BITS-1:0]   ign_key [IGNORE_KEYS],
    input  logic [2:0]            ign_used,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            out_kind,
    output logic [KEY_BITS-1:0]   out_key,
    output logic [VALUE_BITS-1:0] out_value,
    output logic [1:0]            out_verdict,
    output logic [4:0]            out_slot,
    output logic [1:0]            out_status,
    output logic [5:0]            out_fill,
    output logic                  out_last
);
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [KEY_BITS-1:0]   key_mem [TABLE_DEPTH];
    logic [VALUE_BITS-1:0] val_mem [TABLE_DEPTH];

    logic [1:0]            op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [CW-1:0]         fill_reg, idx_reg, n_reg, emit_reg, mv_reg;
    logic                  hit_reg, rd_pend_reg, listed_reg;
    logic [IW-1:0]         match_reg, rd_idx_reg;
    logic [KEY_BITS-1:0]   rd_key_reg;
    logic [VALUE_BITS-1:0] rd_val_reg;
    // Value of the matched slot, captured when the match is seen.
    logic [VALUE_BITS-1:0] val_cmp_reg;
    logic [1:0]            status_c, verdict_c;
    logic [4:0]            slot_c;
    logic                  ov_reg;

    logic                  listed_c;
    logic                  match_c;
    logic [CW-1:0]         n_c;
    logic [6:0]            lim_c;

    always_comb begin
        listed_c = 1'b0;
        for (int i = 0; i < IGNORE_KEYS; i++) begin
            if ((32'(i) < 32'(ign_used)) && ign_key[i] == in_key) begin
                listed_c = 1'b1;
            end
        end
        lim_c = (7'(in_limit) > 7'(MAX_FLUSH)) ? 7'(MAX_FLUSH) : 7'(in_limit);
        n_c = (7'(fill_reg) < lim_c) ? fill_reg : CW'(lim_c);
    end

    assign match_c = rd_pend_reg && (op_reg != OP_FLUSH) && (rd_key_reg == key_reg);

    // Memory ports: one write, one registered read each cycle.
    always_ff @(posedge aclk) begin
        if (cmd.scan_step || cmd.flush_rd) begin
            rd_key_reg <= key_mem[idx_reg[IW-1:0]];
            rd_val_reg <= val_mem[idx_reg[IW-1:0]];
        end else if (cmd.move_step) begin
            rd_key_reg <= key_mem[IW'(mv_reg + n_reg)];
            rd_val_reg <= val_mem[IW'(mv_reg + n_reg)];
        end
        if (cmd.append) begin
            key_mem[fill_reg[IW-1:0]] <= key_reg;
            val_mem[fill_reg[IW-1:0]] <= value_reg;
        end else if (cmd.write_val) begin
            val_mem[match_reg] <= value_reg;
        end else if (rd_pend_reg && op_reg == OP_FLUSH) begin
            key_mem[rd_idx_reg] <= rd_key_reg;
            val_mem[rd_idx_reg] <= rd_val_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            idx_reg     <= '0;
            hit_reg     <= 1'b0;
            rd_pend_reg <= 1'b0;
            ov_reg      <= 1'b0;
            mv_reg      <= '0;
            emit_reg    <= '0;
        end else begin
            rd_pend_reg <= cmd.scan_step || cmd.move_step;
            if (cmd.load) begin
                op_reg     <= in_op;
                key_reg    <= in_key;
                value_reg  <= in_value;
                listed_reg <= listed_c;
                n_reg      <= n_c;
                emit_reg   <= '0;
                mv_reg     <= '0;
            end else begin
                if (cmd.flush_rd) emit_reg <= emit_reg + 1'b1;
                if (cmd.move_step) mv_reg <= mv_reg + 1'b1;
            end
            if (cmd.scan_start) begin
                idx_reg <= '0;
                hit_reg <= 1'b0;
            end else begin
                if (cmd.scan_step || cmd.flush_rd) idx_reg <= idx_reg + 1'b1;
                if (match_c && !hit_reg) begin
                    hit_reg     <= 1'b1;
                    match_reg   <= rd_idx_reg;
                    val_cmp_reg <= rd_val_reg;
                end
            end
            if (cmd.scan_step || cmd.flush_rd) begin
                rd_idx_reg <= idx_reg[IW-1:0];
            end else if (cmd.move_step) begin
                rd_idx_reg <= mv_reg[IW-1:0];
            end
            if (cmd.append) fill_reg <= fill_reg + 1'b1;
            else if (cmd.flush_done) fill_reg <= fill_reg - n_reg;
            if (cmd.out_load) ov_reg <= 1'b1;
            else if (out_valid && out_ready) ov_reg <= 1'b0;
        end
    end

    // Result fields beside the memory read; fill is the value after the item.
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_kind    <= cmd.out_kind;
            out_last    <= cmd.out_last;
            out_key     <= (cmd.out_kind == KIND_ENTRY) ? rd_key_reg : '0;
            out_value   <= (cmd.out_kind == KIND_ENTRY) ? rd_val_reg : '0;
            out_verdict <= (cmd.out_kind == KIND_VERD) ? verdict_c : VD_NONE;
            out_slot    <= (cmd.out_kind == KIND_VERD) ? slot_c : '0;
            out_status  <= (cmd.out_kind == KIND_ACK) ? status_c : MS_UPDATED;
            if (cmd.out_kind == KIND_ENTRY) out_fill <= 6'(fill_reg - n_reg);
            else if (cmd.append)            out_fill <= 6'(fill_reg + 1'b1);
            else                            out_fill <= 6'(fill_reg);
        end
    end

    always_comb begin
        status_c  = hit_reg ? MS_UPDATED
                  : (fill_reg < CW'(TABLE_DEPTH)) ? MS_INSERTED : MS_DROPPED;
        verdict_c = VD_NONE;
        slot_c    = '0;
        if (listed_reg) begin
            if (!hit_reg) begin
                verdict_c = VD_MISSING;
            end else if (val_cmp_reg != value_reg) begin
                verdict_c = VD_DIFFER;
                slot_c    = 5'(match_reg);
            end
        end
    end

    assign out_valid        = ov_reg;
    assign stat.op          = op_reg;
    assign stat.scan_end    = (idx_reg >= fill_reg);
    assign stat.hit         = hit_reg || match_c;
    assign stat.full        = (fill_reg >= CW'(TABLE_DEPTH));
    assign stat.listed      = listed_reg;
    assign stat.flush_empty = (n_reg == '0);
    assign stat.flush_last  = (emit_reg == n_reg);
    assign stat.move_end    = (mv_reg + n_reg >= fill_reg);
    assign stat.out_busy    = ov_reg && !out_ready;
endmodule

// File: design/kpct_ctrl.sv
// Controller: sequences scan, update, flush and result transfers.
module kpct_ctrl import kpct_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  kpct_stat_t stat,
    output kpct_cmd_t  cmd
);
    typedef enum logic [7:0] {
        ST_IDLE  = 8'b00000001,
        ST_DEC   = 8'b00000010,
        ST_SCAN  = 8'b00000100,
        ST_DRAIN = 8'b00001000,
        ST_RES   = 8'b00010000,
        ST_FRD   = 8'b00100000,
        ST_FOUT  = 8'b01000000,
        ST_MOVE  = 8'b10000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.load       = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next     = ST_DEC;
                end
            end
            ST_DEC: begin
                priority if (stat.op == OP_FLUSH) begin
                    state_next = stat.flush_empty ? ST_RES : ST_FRD;
                end else if (stat.op == OP_MERGE || stat.op == OP_QUERY) begin
                    state_next = ST_SCAN;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (stat.hit || stat.scan_end) state_next = ST_DRAIN;
                else cmd.scan_step = 1'b1;
            end
            ST_DRAIN: begin
                state_next = ST_RES;
            end
            ST_RES: begin
                if (!stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = 1'b1;
                    state_next   = ST_IDLE;
                    priority if (stat.op == OP_FLUSH) begin
                        cmd.out_kind = KIND_EMPTY;
                    end else if (stat.op == OP_QUERY) begin
                        cmd.out_kind = KIND_VERD;
                    end else begin
                        cmd.out_kind = KIND_ACK;
                        if (stat.hit)       cmd.write_val = 1'b1;
                        else if (!stat.full) cmd.append   = 1'b1;
                    end
                end
            end
            ST_FRD: begin
                cmd.flush_rd = 1'b1;
                state_next   = ST_FOUT;
            end
            ST_FOUT: begin
                if (!stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = KIND_ENTRY;
                    if (stat.flush_last) begin
                        cmd.out_last = 1'b1;
                        state_next   = ST_MOVE;
                    end else begin
                        state_next = ST_FRD;
                    end
                end
            end
            ST_MOVE: begin
                if (stat.move_end) begin
                    cmd.flush_done = 1'b1;
                    state_next     = ST_IDLE;
                end else begin
                    cmd.move_step = 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
